// ----- hdl/tea_pkg.sv -----
// Shared types and constants for the TEA cipher pipeline.
package tea_pkg;

  localparam logic [31:0] TEA_DELTA = 32'h9e37_79b9;

  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3 = 8'd3;

  typedef struct packed {
    logic [31:0] k0;
    logic [31:0] k1;
    logic [31:0] k2;
    logic [31:0] k3;
  } tea_key_t;

  typedef struct packed {
    logic        valid;
    logic        decrypt;
    logic [31:0] a;
    logic [31:0] b;
  } tea_stage_t;

endpackage

// ----- hdl/tea_half_round.sv -----
// One pipeline stage holding one TEA half-round, encrypt or decrypt.
module tea_half_round
  import tea_pkg::*;
#(
  parameter bit          SECOND_HALF = 1'b0,
  parameter logic [31:0] SUM_ENC     = 32'h0,
  parameter logic [31:0] SUM_DEC     = 32'h0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  tea_key_t   key,
  input  tea_stage_t stage_in,
  output tea_stage_t stage_out
);

  tea_stage_t  stage_r;
  tea_stage_t  stage_nxt;
  logic [31:0] sum;
  logic [31:0] src;
  logic [31:0] ka;
  logic [31:0] kb;
  logic [31:0] mix;
  logic        upd_a;

  // Encrypt: first half updates a from b (k0,k1), second updates b from a (k2,k3).
  // Decrypt: first half updates b from a (k2,k3), second updates a from b (k0,k1).
  always_comb begin
    sum   = stage_in.decrypt ? SUM_DEC : SUM_ENC;
    upd_a = (stage_in.decrypt == SECOND_HALF);
    src   = upd_a ? stage_in.b : stage_in.a;
    ka    = upd_a ? key.k0 : key.k2;
    kb    = upd_a ? key.k1 : key.k3;
    mix   = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);

    stage_nxt = stage_in;
    if (upd_a) begin
      stage_nxt.a = stage_in.decrypt ? stage_in.a - mix : stage_in.a + mix;
    end else begin
      stage_nxt.b = stage_in.decrypt ? stage_in.b - mix : stage_in.b + mix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r.valid <= stage_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r.decrypt <= stage_nxt.decrypt;
      stage_r.a       <= stage_nxt.a;
      stage_r.b       <= stage_nxt.b;
    end
  end

  assign stage_out = stage_r;

endmodule

// ----- hdl/tea_block_cipher.sv -----
// Top level of the pipelined TEA block cipher.
// TEA engine, fully unrolled: one register stage per half-round, 2*ROUND_COUNT stages
// (64 for the default 32 rounds). A new 64-bit block is taken every cycle in which the
// output side does not stall. The whole pipeline advances together; it halts only
// while a finished block waits at the output. in_tuser selects encrypt (0) or decrypt
// (1) per block. Key words are written through the cfg port (indexes 0..3, others
// ignored) and may change only while no block is in flight.
module tea_block_cipher
  import tea_pkg::*;
#(
  parameter int unsigned ROUND_COUNT = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [63:0]          in_tdata,   // first_word, second_word
  input  logic                 in_tuser,   // kind
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [63:0]          out_tdata,  // out_first_word, out_second_word
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int unsigned STAGES = 2 * ROUND_COUNT;

  tea_key_t   key_r;
  tea_stage_t stage [0:STAGES];
  logic       en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r.k0 <= 32'd4;
      key_r.k1 <= 32'd3;
      key_r.k2 <= 32'd2;
      key_r.k3 <= 32'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_KEY_WORD_0: key_r.k0 <= cfg_data;
        CFG_KEY_WORD_1: key_r.k1 <= cfg_data;
        CFG_KEY_WORD_2: key_r.k2 <= cfg_data;
        CFG_KEY_WORD_3: key_r.k3 <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en        = !stage[STAGES].valid || out_tready;
  assign in_tready = en;

  assign stage[0].valid   = in_tvalid;
  assign stage[0].decrypt = in_tuser;
  assign stage[0].a       = in_tdata[31:0];
  assign stage[0].b       = in_tdata[63:32];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam int unsigned RND = s / 2;
    localparam logic [63:0] ENC_P = 64'(RND + 1) * 64'(TEA_DELTA);
    localparam logic [63:0] DEC_P = 64'(ROUND_COUNT - RND) * 64'(TEA_DELTA);

    tea_half_round #(
      .SECOND_HALF(1'((s % 2) != 0)),
      .SUM_ENC    (ENC_P[31:0]),
      .SUM_DEC    (DEC_P[31:0])
    ) u_half (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .key      (key_r),
      .stage_in (stage[s]),
      .stage_out(stage[s+1])
    );
  end

  assign out_tvalid = stage[STAGES].valid;
  assign out_tdata  = {stage[STAGES].b, stage[STAGES].a};

endmodule

// ----- hdl/tea_checker.sv -----
// Port-level assertions for the TEA cipher and their bind.
module tea_port_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output transfer changed");

  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked while output empty");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while pipeline stalled");

endmodule

bind tea_block_cipher tea_port_props u_tea_port_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
